@@ sv/acs_pkg.sv @@
package acs_pkg;

	localparam int NumWords = 60;
	localparam int RkAddrW = 6;
	localparam int CfgAddrW = 6;

	typedef enum logic [2:0] {
		CfgKey0 = 3'd0,
		CfgKey1 = 3'd1,
		CfgKey2 = 3'd2,
		CfgKey3 = 3'd3,
		CfgLocal = 3'd4,
		CfgRemote = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [4:0] byte_count;
		logic first_block;
		logic last_block;
		logic [15:0] block_seq;
		logic use_key;
		logic invert_ids;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_hi;
		logic [63:0] out_lo;
		logic [4:0] out_count;
		logic out_last;
	} out_item_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// One AES round on a state whose byte 0 sits in the top bits.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] sb [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) sb[i] = sbox(s[127 - 8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i + 4*c] = sb[i + 4*((c + i) & 3)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (last) begin
				r[127 - 32*c -: 32] = {a0, a1, a2, a3};
			end else begin
				r[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
					a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
			end
		end
		return r;
	endfunction

endpackage

@@ sv/acs_stream_if.sv @@
interface acs_stream_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/acs_ram.sv @@
module acs_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ sv/aes256_ctr_session_crypt_unit.sv @@
// AES-256 counter-mode cipher for packets, one 16-byte block per request.
// The input channel carries a block with its byte count and framing flags;
// the output channel returns the block XORed with the keystream, bytes past
// the count set to zero. A first block expands the key schedule, one word
// per cycle, into 60 words of the round key RAM, then loads the session
// word from the session ids and the counter from the sequence number.
// Each block then runs the shared round unit, reading the four round key
// words of each round in turn from the single RAM port, over the initial
// key addition and fourteen rounds; the state is loaded before and the
// result registered for output after. A first block adds the expansion.
// The block takes one request at a time; in_ch.ready is high only when idle
// and no result is held. A stalled receiver holds the result in the output
// register and the block waits. Reset idles the control and zeroes the
// configuration, session word and counter. Configuration is written over
// the APB port and is used at the next first block.
module aes256_ctr_session_crypt_unit (
	input logic clk,
	input logic arst_n,
	acs_stream_if.sink in_ch,
	acs_stream_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [acs_pkg::CfgAddrW-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import acs_pkg::*;

	typedef enum logic [4:0] {
		StIdle = 5'b00001,
		StExp = 5'b00010,
		StLoad = 5'b00100,
		StRound = 5'b01000,
		StOut = 5'b10000
	} state_t;

	state_t state_q;
	logic [63:0] key_q [4];
	logic [15:0] local_q, remote_q;
	logic [31:0] session_q, counter_q;
	in_item_t item_q;
	logic [127:0] st_q;
	logic [127:0] rk_q;
	logic [31:0] win_q [8];
	logic [5:0] idx_q;
	logic [3:0] round_q;
	logic [1:0] col_q;
	logic out_valid_q;
	out_item_t out_q;

	logic we;
	logic [RkAddrW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata, t, kw;
	logic [2:0] reg_sel;
	logic [127:0] ks, xd, din;
	in_item_t in_item, in_sat;

	assign in_item = in_ch.data;
	assign pready = 1'b1;
	assign reg_sel = paddr[5:3];

	always_comb begin
		in_sat = in_item;
		if (in_item.byte_count > 5'd16) in_sat.byte_count = 5'd16;
	end

	always_comb begin
		case (reg_sel)
			CfgKey0: prdata = key_q[0];
			CfgKey1: prdata = key_q[1];
			CfgKey2: prdata = key_q[2];
			CfgKey3: prdata = key_q[3];
			CfgLocal: prdata = {48'd0, local_q};
			CfgRemote: prdata = {48'd0, remote_q};
			default: prdata = '0;
		endcase
	end

	// Key expansion word from the sliding window of the last eight words.
	always_comb begin
		t = win_q[7];
		if (idx_q[2:0] == 3'd0) begin
			t = sub_word({t[23:0], t[31:24]}) ^ ({24'd0, 8'd1} << (idx_q[5:3] - 3'd1)) << 24;
		end else if (idx_q[2:0] == 3'd4) begin
			t = sub_word(t);
		end
		kw = (idx_q < 6'd8) ? (item_q.use_key ?
			(idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32]) : 32'd0)
			: win_q[0] ^ t;
	end

	assign we = (state_q == StExp);
	assign waddr = idx_q;
	assign wdata = kw;
	// The last column of a round already addresses the next round's first word.
	assign raddr = {round_q + {3'd0, (state_q == StRound) && (col_q == 2'd0)}, col_q};

	acs_ram #(.Width(32), .Depth(64)) u_rk (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign ks = st_q;
	assign din = {item_q.data_hi, item_q.data_lo};
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			xd[127 - 8*i -: 8] = (5'(i) < item_q.byte_count) ?
				(din[127 - 8*i -: 8] ^ ks[127 - 8*i -: 8]) : 8'd0;
		end
	end

	assign in_ch.ready = (state_q == StIdle) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			local_q <= '0;
			remote_q <= '0;
			session_q <= '0;
			counter_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			round_q <= '0;
			col_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (reg_sel)
					CfgKey0: key_q[0] <= pwdata;
					CfgKey1: key_q[1] <= pwdata;
					CfgKey2: key_q[2] <= pwdata;
					CfgKey3: key_q[3] <= pwdata;
					CfgLocal: local_q <= pwdata[15:0];
					CfgRemote: remote_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_sat;
						idx_q <= '0;
						round_q <= '0;
						col_q <= '0;
						if (in_item.first_block) begin
							state_q <= StExp;
						end else begin
							state_q <= StLoad;
						end
					end
				end
				StExp: begin
					for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
					win_q[7] <= kw;
					if (idx_q == 6'(NumWords - 1)) begin
						state_q <= StLoad;
						session_q <= (item_q.use_key ? {local_q, remote_q} : 32'd0)
							^ {32{item_q.invert_ids}};
						counter_q <= {item_q.block_seq, 16'd0};
					end
					idx_q <= idx_q + 6'd1;
				end
				StLoad: begin
					st_q <= {session_q, session_q, 32'd0, counter_q};
					col_q <= 2'd1;
					state_q <= StRound;
				end
				StRound: begin
					// Round key words arrive from the registered RAM read in the cycle after their address.
					rk_q <= {rk_q[95:0], rdata};
					col_q <= col_q + 2'd1;
					if (col_q == 2'd0) begin
						if (round_q == 4'd0) begin
							st_q <= st_q ^ {rk_q[95:0], rdata};
						end else begin
							st_q <= aes_round(st_q, round_q == 4'd14) ^ {rk_q[95:0], rdata};
						end
						if (round_q == 4'd14) begin
							state_q <= StOut;
						end
						round_q <= round_q + 4'd1;
					end
				end
				StOut: begin
					out_q <= '{out_hi: xd[127:64], out_lo: xd[63:0],
						out_count: item_q.byte_count, out_last: item_q.last_block};
					out_valid_q <= 1'b1;
					counter_q <= counter_q + 32'd1;
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
